[rtl/msp_pkg.sv]
// Shared types, widths and constants for the moving sphere versus plane test.
`default_nettype none
package msp_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int NRM_W     = 18;
  localparam int SIZE_W    = 31;
  localparam int RAD_W     = SIZE_W - 1;

  // Dot product widths.
  localparam int DIFF_W = CRD_W + 1;
  localparam int PD_W   = DIFF_W + NRM_W;
  localparam int PV_W   = CRD_W + NRM_W;
  localparam int DSUM_W = PD_W + 2;
  localparam int VSUM_W = PV_W + 2;
  localparam int D_W    = DSUM_W - FRAC_BITS;
  localparam int DN_W   = VSUM_W - FRAC_BITS;

  // Divider widths.
  localparam int NUM_W     = D_W + 1;
  localparam int QN_W      = NUM_W + FRAC_BITS;
  localparam int QB        = CRD_W;
  localparam int DIV_CMP_W = DN_W + QB;

  // Contact point widths.
  localparam int TV_W  = 2 * CRD_W;
  localparam int SN_W  = RAD_W + 1 + NRM_W;
  localparam int TVS_W = TV_W - FRAC_BITS;
  localparam int SNS_W = SN_W - FRAC_BITS;
  localparam int SUM_W = TVS_W + 2;

  // Saturation limits.
  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic [QB-1:0]           Q_MIN_MAG = {1'b1, {(QB-1){1'b0}}};

  // Configuration register map.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_PPX = 3'd0;
  localparam logic [2:0] REG_PPY = 3'd1;
  localparam logic [2:0] REG_PPZ = 3'd2;
  localparam logic [2:0] REG_PNX = 3'd3;
  localparam logic [2:0] REG_PNY = 3'd4;
  localparam logic [2:0] REG_PNZ = 3'd5;
  localparam logic [NRM_W-1:0] NRM_ONE = NRM_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_OVERLAP = 2'd1,
    KIND_HIT     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] pt;
    logic [2:0][NRM_W-1:0] nm;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]     size;
    logic [2:0][CRD_W-1:0] v;
    logic [2:0][CRD_W-1:0] c;
  } sph_t;

  // Classified item handed to the divider.
  typedef struct packed {
    kind_e                 kind;
    logic                  neg;
    logic [NUM_W-1:0]      mag;
    logic [DN_W-1:0]       md;
    logic [RAD_W:0]        s;
    logic [2:0][CRD_W-1:0] c;
    logic [2:0][CRD_W-1:0] v;
  } cls_t;

  // Quotient and context handed to the contact stages.
  typedef struct packed {
    kind_e                 kind;
    logic                  neg;
    logic                  ovf;
    logic [QB-1:0]         q;
    logic [RAD_W:0]        s;
    logic [2:0][CRD_W-1:0] c;
    logic [2:0][CRD_W-1:0] v;
  } div_t;

  typedef struct packed {
    kind_e                 kind;
    logic [CRD_W-1:0]      t;
    logic                  tsat;
    logic [2:0][CRD_W-1:0] cp;
  } res_t;

endpackage
`default_nettype wire

[rtl/msp_dot.sv]
// Distance and normal speed dot products, then hit classification (three stages).
`default_nettype none
module msp_dot import msp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  sph_t sph_i,
  input  cfg_t cfg_i,
  output logic vld_o,
  output cls_t cls_o
);

  logic signed [DIFF_W-1:0] diff [3];
  logic signed [PD_W-1:0]   pd_d [3];
  logic signed [PD_W-1:0]   pd_q [3];
  logic signed [PV_W-1:0]   pv_d [3];
  logic signed [PV_W-1:0]   pv_q [3];
  sph_t                     sph_a_q, sph_b_q;
  logic                     vld_a_q, vld_b_q, vld_c_q;

  logic signed [DSUM_W-1:0] dsum, dbias;
  logic signed [VSUM_W-1:0] vsum, vbias;
  logic signed [D_W-1:0]    d_d, d_q;
  logic signed [DN_W-1:0]   dn_d, dn_q;

  logic [RAD_W-1:0]        r;
  logic [D_W-1:0]          absd;
  logic                    dpos, dnz, dnpos;
  logic signed [RAD_W:0]   s;
  logic signed [NUM_W-1:0] num;
  cls_t                    cls_d, cls_q;

  // Stage A: per-axis products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'($signed(sph_i.c[i])) - DIFF_W'($signed(cfg_i.pt[i]));
      pd_d[i] = diff[i] * $signed(cfg_i.nm[i]);
      pv_d[i] = $signed(cfg_i.nm[i]) * $signed(sph_i.v[i]);
    end
  end

  // Stage B: sums, scaled back with truncation toward zero.
  always_comb begin
    dsum  = DSUM_W'(pd_q[0]) + DSUM_W'(pd_q[1]) + DSUM_W'(pd_q[2]);
    vsum  = VSUM_W'(pv_q[0]) + VSUM_W'(pv_q[1]) + VSUM_W'(pv_q[2]);
    dbias = dsum + DSUM_W'({FRAC_BITS{dsum[DSUM_W-1]}});
    vbias = vsum + VSUM_W'({FRAC_BITS{vsum[VSUM_W-1]}});
    d_d   = dbias[DSUM_W-1:FRAC_BITS];
    dn_d  = vbias[VSUM_W-1:FRAC_BITS];
  end

  // Stage C: overlap and approach tests, divider operands.
  always_comb begin
    r     = sph_b_q.size[SIZE_W-1:1];
    absd  = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
    dpos  = !d_q[D_W-1];
    dnz   = (dn_q != '0);
    dnpos = !dn_q[DN_W-1] && dnz;
    s     = dpos ? $signed({1'b0, r}) : -$signed({1'b0, r});
    num   = NUM_W'(s) - NUM_W'(d_q);
    cls_d.neg  = num[NUM_W-1] ^ dn_q[DN_W-1];
    cls_d.mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    cls_d.md   = dn_q[DN_W-1] ? DN_W'(-dn_q) : DN_W'(dn_q);
    cls_d.s    = s;
    cls_d.c    = sph_b_q.c;
    cls_d.v    = sph_b_q.v;
    if (absd <= D_W'(r)) begin
      cls_d.kind = KIND_OVERLAP;
    end else if (!dnz || (dnpos == dpos)) begin
      cls_d.kind = KIND_NONE;
    end else begin
      cls_d.kind = KIND_HIT;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= pd_d[i];
        pv_q[i] <= pv_d[i];
      end
      sph_a_q <= sph_i;
      d_q     <= d_d;
      dn_q    <= dn_d;
      sph_b_q <= sph_a_q;
      cls_q   <= cls_d;
    end
  end

  assign vld_o = vld_c_q;
  assign cls_o = cls_q;

endmodule
`default_nettype wire

[rtl/msp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`default_nettype none
module msp_div import msp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  cls_t cls_i,
  output logic vld_o,
  output div_t div_o
);

  logic [QN_W-1:0] rem_q [QB+1];
  logic [QB-1:0]   q_q   [QB+1];
  logic            ovf_q [QB+1];
  cls_t            pay_q [QB+1];
  logic            vld_q [QB+1];

  logic [QN_W-1:0] n_d;
  logic            ovf_d;

  // Prep stage: scaled numerator and quotient overflow check.
  always_comb begin
    n_d   = {cls_i.mag, {FRAC_BITS{1'b0}}};
    ovf_d = DIV_CMP_W'(n_d) >= {cls_i.md, {QB{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_d;
      q_q[0]   <= '0;
      ovf_q[0] <= ovf_d;
      pay_q[0] <= cls_i;
    end
  end

  // Bit stages, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int B = QB - 1 - k;
    logic [DIV_CMP_W-1:0] dv;
    logic [DIV_CMP_W-1:0] rw;
    logic                 ge;

    always_comb begin
      dv = DIV_CMP_W'(pay_q[k].md) << B;
      rw = DIV_CMP_W'(rem_q[k]);
      ge = (rw >= dv);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? QN_W'(rw - dv) : rem_q[k];
        q_q[k+1]   <= q_q[k] | (QB'(ge) << B);
        ovf_q[k+1] <= ovf_q[k];
        pay_q[k+1] <= pay_q[k];
      end
    end
  end

  always_comb begin
    div_o.kind = pay_q[QB].kind;
    div_o.neg  = pay_q[QB].neg;
    div_o.ovf  = ovf_q[QB];
    div_o.q    = q_q[QB];
    div_o.s    = pay_q[QB].s;
    div_o.c    = pay_q[QB].c;
    div_o.v    = pay_q[QB].v;
  end

  assign vld_o = vld_q[QB];

endmodule
`default_nettype wire

[rtl/msp_ctc.sv]
// Time saturation, contact point products and sums, and the output register.
`default_nettype none
module msp_ctc import msp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  div_t div_i,
  input  cfg_t cfg_i,
  output logic vld_o,
  output res_t res_o
);

  logic signed [CRD_W-1:0] t_d, t_q;
  logic                    tsat_d, tsat_q, tsat_f_q;
  logic signed [CRD_W-1:0] t_f_q;
  div_t                    ctx_e_q, ctx_f_q;
  logic                    vld_e_q, vld_f_q, vld_g_q;

  logic signed [TV_W-1:0]  tv_d [3];
  logic signed [TV_W-1:0]  tv_q [3];
  logic signed [SN_W-1:0]  sn_d [3];
  logic signed [SN_W-1:0]  sn_q [3];

  logic signed [TV_W-1:0]  tvb  [3];
  logic signed [SN_W-1:0]  snb  [3];
  logic signed [SUM_W-1:0] sum  [3];
  logic [2:0][CRD_W-1:0]   cp;
  res_t                    res_d, res_q;

  // Stage E: signed, clamped hit time.
  always_comb begin
    t_d    = '0;
    tsat_d = 1'b0;
    if (div_i.ovf) begin
      tsat_d = 1'b1;
      t_d    = div_i.neg ? CRD_MIN : CRD_MAX;
    end else if (div_i.neg) begin
      if (div_i.q > Q_MIN_MAG) begin
        tsat_d = 1'b1;
        t_d    = CRD_MIN;
      end else begin
        t_d = -$signed(div_i.q);
      end
    end else if (div_i.q[QB-1]) begin
      tsat_d = 1'b1;
      t_d    = CRD_MAX;
    end else begin
      t_d = $signed(div_i.q);
    end
  end

  // Stage F: travel and radius offset products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv_d[i] = t_q * $signed(ctx_e_q.v[i]);
      sn_d[i] = $signed(ctx_e_q.s) * $signed(cfg_i.nm[i]);
    end
  end

  // Stage G: scale, sum and clamp the contact point, select by kind.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tvb[i] = tv_q[i] + TV_W'({FRAC_BITS{tv_q[i][TV_W-1]}});
      snb[i] = sn_q[i] + SN_W'({FRAC_BITS{sn_q[i][SN_W-1]}});
      sum[i] = SUM_W'($signed(ctx_f_q.c[i]))
             + SUM_W'($signed(tvb[i][TV_W-1:FRAC_BITS]))
             - SUM_W'($signed(snb[i][SN_W-1:FRAC_BITS]));
      if (sum[i] > SUM_W'(CRD_MAX)) begin
        cp[i] = CRD_MAX;
      end else if (sum[i] < SUM_W'(CRD_MIN)) begin
        cp[i] = CRD_MIN;
      end else begin
        cp[i] = sum[i][CRD_W-1:0];
      end
    end
    res_d.kind = ctx_f_q.kind;
    case (ctx_f_q.kind)
      KIND_HIT: begin
        res_d.t    = t_f_q;
        res_d.tsat = tsat_f_q;
        res_d.cp   = cp;
      end
      KIND_OVERLAP: begin
        res_d.t    = '0;
        res_d.tsat = 1'b0;
        res_d.cp   = ctx_f_q.c;
      end
      default: begin
        res_d.t    = '0;
        res_d.tsat = 1'b0;
        res_d.cp   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
    end else if (en_i) begin
      vld_e_q <= vld_i;
      vld_f_q <= vld_e_q;
      vld_g_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_d;
      tsat_q   <= tsat_d;
      ctx_e_q  <= div_i;
      for (int i = 0; i < 3; i++) begin
        tv_q[i] <= tv_d[i];
        sn_q[i] <= sn_d[i];
      end
      t_f_q    <= t_q;
      tsat_f_q <= tsat_q;
      ctx_f_q  <= ctx_e_q;
      res_q    <= res_d;
    end
  end

  assign vld_o = vld_g_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

[rtl/moving_sphere_plane_intersect_core.sv]
// Top level: configuration registers, stream ports and the processing pipeline.
// Pipeline: 39 register stages (3 dot product and classify stages, 33 divider
// stages, 3 contact stages). Throughput: one item per cycle; the restoring
// divider's 32 bit stages, one quotient bit per stage, set the depth. The whole
// pipeline holds while the output waits. Reset clears all valid bits and loads
// the plane registers with their defaults.
`default_nettype none
module moving_sphere_plane_intersect_core import msp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Sphere items in.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // center_x, center_y, center_z, vel_x, vel_y, vel_z, size_value, zero pad
  input  logic [223:0]      s_axis_tdata,
  // Results out.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // hit_time, time_saturated, contact_x, contact_y, contact_z,
  // normal_out_x, normal_out_y, normal_out_z, zero pad
  output logic [183:0]      m_axis_tdata,
  // result_kind
  output logic [1:0]        m_axis_tuser
);

  cfg_t cfg_q;
  sph_t sph;
  logic en;
  logic dot_vld, div_vld, res_vld;
  cls_t cls;
  div_t dres;
  res_t res;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pt    <= '0;
      cfg_q.nm[0] <= '0;
      cfg_q.nm[1] <= NRM_ONE;
      cfg_q.nm[2] <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_PPX: cfg_q.pt[0] <= pwdata;
        REG_PPY: cfg_q.pt[1] <= pwdata;
        REG_PPZ: cfg_q.pt[2] <= pwdata;
        REG_PNX: cfg_q.nm[0] <= pwdata[NRM_W-1:0];
        REG_PNY: cfg_q.nm[1] <= pwdata[NRM_W-1:0];
        REG_PNZ: cfg_q.nm[2] <= pwdata[NRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration reads; normals read back sign extended.
  always_comb begin
    case (paddr[4:2])
      REG_PPX: prdata = cfg_q.pt[0];
      REG_PPY: prdata = cfg_q.pt[1];
      REG_PPZ: prdata = cfg_q.pt[2];
      REG_PNX: prdata = 32'($signed(cfg_q.nm[0]));
      REG_PNY: prdata = 32'($signed(cfg_q.nm[1]));
      REG_PNZ: prdata = 32'($signed(cfg_q.nm[2]));
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // The pipeline moves whenever the output register is free or being drained.
  assign en            = !res_vld || m_axis_tready;
  assign s_axis_tready = en;

  assign sph.c    = s_axis_tdata[95:0];
  assign sph.v    = s_axis_tdata[191:96];
  assign sph.size = s_axis_tdata[222:192];

  msp_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .sph_i  (sph),
    .cfg_i  (cfg_q),
    .vld_o  (dot_vld),
    .cls_o  (cls)
  );

  msp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dot_vld),
    .cls_i  (cls),
    .vld_o  (div_vld),
    .div_o  (dres)
  );

  msp_ctc u_ctc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (div_vld),
    .div_i  (dres),
    .cfg_i  (cfg_q),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  // Output packing.
  assign m_axis_tvalid = res_vld;
  assign m_axis_tuser  = res.kind;
  assign m_axis_tdata  = {1'b0, cfg_q.nm[2], cfg_q.nm[1], cfg_q.nm[0],
                          res.cp[2], res.cp[1], res.cp[0], res.tsat, res.t};

  // A miss carries no time, flag or contact point.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_NONE) |-> (m_axis_tdata[128:0] == '0))
    else $error("miss result carries nonzero payload");

  // An overlap reports zero time and no saturation.
  a_ovl_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_OVERLAP) |-> (m_axis_tdata[32:0] == '0))
    else $error("overlap result carries nonzero time");

  // Saturation is only flagged on an approaching hit.
  a_sat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> (m_axis_tuser == KIND_HIT))
    else $error("time saturation flagged without a hit");

endmodule
`default_nettype wire
